FILE: rtl/lmsd_pkg.sv
package lmsd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE  = 2'd1;

  // Field widths
  localparam int BTN_W   = 2;
  localparam int WORD_W  = 16;
  localparam int GLYPH_W = 64;
  localparam int PHASE_W = 4;

  // Top select bit of the drive word
  localparam logic [WORD_W-1:0] SEL_TOP = 16'h8000;

  // Scan modes
  localparam logic MODE_COLUMN = 1'b0;
  localparam logic MODE_ROW    = 1'b1;

  // Control from the top level to the scan generator
  typedef struct packed {
    logic step;       // one tick accepted
    logic phase_clr;  // mode register written
  } scan_ctl_t;

  // One result
  typedef struct packed {
    logic [WORD_W-1:0] drive_word;
    logic [BTN_W-1:0]  debounced_buttons;
    logic [BTN_W-1:0]  press_edges;
  } result_t;

endpackage

FILE: rtl/led_matrix_scan_with_button_debounce.sv
// A request's result is registered in out_r, or in the skid stage while out_* stalls.
// Throughput: one request per cycle while the skid stage is empty; an output register
// plus a skid stage keep in_ready high while one finished result waits for out_ready.
// Reset (rst_n low at a clock edge, synchronous): clears the samples, the debounced
// state, the scan phase, the glyph and mode registers, and the output valid flags.
module led_matrix_scan_with_button_debounce (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [lmsd_pkg::BTN_W-1:0]             in_button_pins,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [lmsd_pkg::WORD_W-1:0]            out_drive_word,
  output logic [lmsd_pkg::BTN_W-1:0]             out_debounced_buttons,
  output logic [lmsd_pkg::BTN_W-1:0]             out_press_edges,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lmsd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lmsd_pkg::GLYPH_W-1:0]           cfg_data
);

  logic [lmsd_pkg::GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic                         mode_r, mode_nxt;
  logic                         cfg_wr;
  logic                         in_acc;
  logic                         out_pop;
  lmsd_pkg::scan_ctl_t          scan_ctl;
  lmsd_pkg::result_t            res;
  lmsd_pkg::result_t            out_r, out_nxt;
  lmsd_pkg::result_t            skid_r, skid_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         skid_valid_r, skid_valid_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_ready  = !skid_valid_r;
  assign in_acc    = in_valid & in_ready;
  assign out_pop   = out_valid_r & out_ready;

  // Configuration registers
  always_comb begin
    glyph_nxt = glyph_r;
    mode_nxt  = mode_r;
    if (cfg_wr && (cfg_index == lmsd_pkg::CFG_GLYPH_ROWS)) begin
      glyph_nxt = cfg_data;
    end
    if (cfg_wr && (cfg_index == lmsd_pkg::CFG_SCAN_MODE)) begin
      mode_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r <= '0;
      mode_r  <= lmsd_pkg::MODE_COLUMN;
    end else begin
      glyph_r <= glyph_nxt;
      mode_r  <= mode_nxt;
    end
  end

  assign scan_ctl.step      = in_acc;
  assign scan_ctl.phase_clr = cfg_wr && (cfg_index == lmsd_pkg::CFG_SCAN_MODE);

  lmsd_debounce u_debounce (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .pins      (in_button_pins),
    .debounced (res.debounced_buttons),
    .edges     (res.press_edges)
  );

  lmsd_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .mode       (mode_r),
    .glyph      (glyph_r),
    .drive_word (res.drive_word)
  );

  // Output register with skid stage
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_acc;
      end
    end else if (in_acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_drive_word        = out_r.drive_word;
  assign out_debounced_buttons = out_r.debounced_buttons;
  assign out_press_edges       = out_r.press_edges;

`ifndef SYNTHESIS
  // Skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // A request taken while the output stalls lands in the skid stage
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("request lost under output stall");

  // A press pulse only on a button that reads pressed
  a_edge_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_press_edges & ~out_debounced_buttons) == '0))
    else $error("press edge without debounced press");

  // At most one select line active
  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0(out_drive_word[15:8]))
    else $error("more than one select line driven");
`endif

endmodule

FILE: rtl/lmsd_debounce.sv
module lmsd_debounce (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [lmsd_pkg::BTN_W-1:0] pins,
  output logic [lmsd_pkg::BTN_W-1:0] debounced,
  output logic [lmsd_pkg::BTN_W-1:0] edges
);

  logic [lmsd_pkg::BTN_W-1:0] last_r, last_nxt;
  logic [lmsd_pkg::BTN_W-1:0] older_r, older_nxt;
  logic [lmsd_pkg::BTN_W-1:0] stable_r, stable_nxt;
  logic [lmsd_pkg::BTN_W-1:0] sample;

  // Pins are active low; take a new value after three agreeing samples
  always_comb begin
    sample     = ~pins;
    last_nxt   = last_r;
    older_nxt  = older_r;
    stable_nxt = stable_r;
    if (step) begin
      if ((older_r == last_r) && (last_r == sample)) begin
        stable_nxt = sample;
      end
      older_nxt = last_r;
      last_nxt  = sample;
    end
  end

  assign debounced = stable_nxt;
  assign edges     = stable_nxt & ~stable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      older_r  <= '0;
      stable_r <= '0;
    end else begin
      last_r   <= last_nxt;
      older_r  <= older_nxt;
      stable_r <= stable_nxt;
    end
  end

endmodule

FILE: rtl/lmsd_scan.sv
module lmsd_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lmsd_pkg::scan_ctl_t          ctl,
  input  logic                         mode,
  input  logic [lmsd_pkg::GLYPH_W-1:0] glyph,
  output logic [lmsd_pkg::WORD_W-1:0]  drive_word
);

  logic [lmsd_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [lmsd_pkg::PHASE_W-1:0] phase_adv;
  logic [2:0]                   p;
  logic [7:0]                   pat;
  logic [lmsd_pkg::WORD_W-1:0]  sel;

  // Drive word for the current phase
  always_comb begin
    logic [7:0] row_v;
    row_v = '0;
    p   = phase_r[2:0];
    sel = lmsd_pkg::SEL_TOP >> p;
    pat = '0;
    if (mode == lmsd_pkg::MODE_ROW) begin
      pat        = glyph[8*p +: 8];
      drive_word = sel | {8'h00, pat};
      phase_adv  = {1'b0, p + 3'd1};
    end else if (!phase_r[3]) begin
      // Column p: bit (7-p) of every glyph row, transposed
      for (int j = 0; j < 8; j++) begin
        row_v  = glyph[8*j +: 8];
        pat[j] = row_v[~p];
      end
      drive_word = sel | {8'h00, pat};
      phase_adv  = phase_r + 4'd1;
    end else begin
      // Blank phase
      drive_word = '0;
      phase_adv  = '0;
    end
  end

  // Phase register
  always_comb begin
    phase_nxt = phase_r;
    if (ctl.phase_clr) begin
      phase_nxt = '0;
    end else if (ctl.step) begin
      phase_nxt = phase_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: dv/scan_checker.sv
`timescale 1ns / 100ps

module scan_checker
  import lmsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [BTN_W-1:0]     in_button_pins,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [WORD_W-1:0]    out_drive_word,
  input  logic [BTN_W-1:0]     out_debounced_buttons,
  input  logic [BTN_W-1:0]     out_press_edges,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GLYPH_W-1:0]   cfg_data,
  output int                   outstanding,
  output int                   error_count
);

  // Shadow copy of the block's registers and state
  logic [GLYPH_W-1:0] glyph;
  logic               mode;
  logic [BTN_W-1:0]   last_smp;
  logic [BTN_W-1:0]   older_smp;
  logic [BTN_W-1:0]   stable_btn;
  logic [PHASE_W-1:0] phase;

  // Drive words and button states still owed by the block, oldest first
  result_t scan_results_q[$];

  // One scan tick: debounce the pins, build the drive word, step the phase
  task automatic scan_tick(input logic [BTN_W-1:0] pins, output result_t res);
    logic [BTN_W-1:0] sample;
    logic [BTN_W-1:0] prev;
    logic [2:0]       p;
    logic [7:0]       pattern;
    sample = ~pins;
    prev   = stable_btn;
    if (older_smp == last_smp && last_smp == sample) stable_btn = sample;
    older_smp = last_smp;
    last_smp  = sample;

    res.drive_word = '0;
    if (mode == MODE_ROW) begin
      // row scan wraps modulo 8
      p = phase[2:0];
      res.drive_word = (SEL_TOP >> p) | {8'h00, glyph[8*p +: 8]};
      phase = {1'b0, 3'(p + 3'd1)};
    end else if (phase < 4'd8) begin
      // column scan: pattern is column p taken across the eight rows
      p = phase[2:0];
      for (int j = 0; j < 8; j++) pattern[j] = glyph[8*j + 7 - p];
      res.drive_word = (SEL_TOP >> p) | {8'h00, pattern};
      phase = phase + 4'd1;
    end else begin
      // blank phase, word stays zero
      phase = '0;
    end
    res.debounced_buttons = stable_btn;
    res.press_edges       = stable_btn & ~prev;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      glyph       = '0;
      mode        = MODE_COLUMN;
      last_smp    = '0;
      older_smp   = '0;
      stable_btn  = '0;
      phase       = '0;
      error_count = 0;
      scan_results_q.delete();
      outstanding <= 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GLYPH_ROWS) begin
          glyph = cfg_data;
        end else if (cfg_index == CFG_SCAN_MODE) begin
          mode  = cfg_data[0];
          phase = '0;
        end
      end

      // accepted tick request
      if (in_valid && in_ready) begin
        scan_tick(in_button_pins, want);
        scan_results_q.push_back(want);
      end

      // accepted result
      if (out_valid && out_ready) begin
        if (scan_results_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word=%h deb=%b edge=%b", $time,
                   out_drive_word, out_debounced_buttons, out_press_edges);
        end else begin
          want = scan_results_q.pop_front();
          if (out_drive_word !== want.drive_word) begin
            error_count++;
            $display("%0t: drive_word expected %h got %h", $time,
                     want.drive_word, out_drive_word);
          end
          if (out_debounced_buttons !== want.debounced_buttons) begin
            error_count++;
            $display("%0t: debounced_buttons expected %b got %b", $time,
                     want.debounced_buttons, out_debounced_buttons);
          end
          if (out_press_edges !== want.press_edges) begin
            error_count++;
            $display("%0t: press_edges expected %b got %b", $time,
                     want.press_edges, out_press_edges);
          end
        end
      end
      outstanding <= scan_results_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lmsd_pkg::*;

  // indexes past the register list, the block ignores them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int TICKS_PER_PHASE = 180;
  localparam int NUM_PHASES      = 8;

  // press both, release, press each alone, then short bounces, each followed by a held level that latches
  localparam logic [BTN_W-1:0] DIRECTED_PINS [23] = '{
    2'b11, 2'b00, 2'b00, 2'b00, 2'b11, 2'b11, 2'b11, 2'b10, 2'b10, 2'b10,
    2'b01, 2'b01, 2'b01, 2'b00, 2'b01, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00,
    2'b11, 2'b11, 2'b11
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BTN_W-1:0]     in_button_pins;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    out_drive_word;
  logic [BTN_W-1:0]     out_debounced_buttons;
  logic [BTN_W-1:0]     out_press_edges;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GLYPH_W-1:0]   cfg_data;
  int                   outstanding;
  int                   error_count;
  int                   idle_pct;
  int                   stall_pct;

  led_matrix_scan_with_button_debounce DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_button_pins        (in_button_pins),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_drive_word        (out_drive_word),
    .out_debounced_buttons (out_debounced_buttons),
    .out_press_edges       (out_press_edges),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  scan_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_button_pins        (in_button_pins),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_drive_word        (out_drive_word),
    .out_debounced_buttons (out_debounced_buttons),
    .out_press_edges       (out_press_edges),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .outstanding           (outstanding),
    .error_count           (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one tick request, with random sender gaps ahead of it
  task automatic send_tick(input logic [BTN_W-1:0] pins);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_button_pins <= pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GLYPH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and let every owed result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [GLYPH_W-1:0] wdata;
    logic [BTN_W-1:0]   pins;
    int                 sent;
    int                 run_len;
    in_valid       = 1'b0;
    in_button_pins = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_GLYPH_ROWS;
    cfg_data       = '0;
    rst_n          = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: column scan over an asymmetric glyph, debounce corners
    write_reg(CFG_GLYPH_ROWS, 64'h8142_2418_0F0F_A5C3);
    write_reg(CFG_SCAN_MODE, {{(GLYPH_W-1){1'b0}}, MODE_COLUMN});
    foreach (DIRECTED_PINS[k]) send_tick(DIRECTED_PINS[k]);
    wait_idle();

    // random phases: new glyph each time, mode not always rewritten
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase

      if (ph == 0)      wdata = '1;
      else if (ph == 1) wdata = '0;
      else              wdata = {$urandom, $urandom};
      write_reg(CFG_GLYPH_ROWS, wdata);

      if (ph % 3 != 2) begin
        wdata    = {$urandom, $urandom};
        wdata[0] = (ph % 2 == 1) ? MODE_ROW : MODE_COLUMN;
        write_reg(CFG_SCAN_MODE, wdata);
      end
      if (ph % 4 == 3) begin
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
      end

      // mostly held levels long enough to latch, some single-tick glitches
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        pins    = BTN_W'($urandom_range(3));
        run_len = ($urandom_range(99) < 80) ? $urandom_range(3, 7) : 1;
        repeat (run_len) begin
          send_tick(pins);
          sent++;
        end
      end
      wait_idle();
    end

    repeat (5) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
